// ===== rtl/core/lsr_pkg.sv =====
// Shared constants, types and helpers of the label segment reassembler.
`timescale 1ns / 1ps
`default_nettype none
package lsr_pkg;

  localparam int NUM_SEGMENTS  = 8;
  localparam int SEGMENT_BYTES = 16;

  localparam int IDX_W  = 3;
  localparam int LEN_W  = 5;
  localparam int TOT_W  = 4;
  localparam int CS_W   = 4;
  localparam int IN_W   = 128;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W = WORD_BYTES * 8;
  localparam int CNT_W  = 4;
  localparam int MLEN_W = 8;

  localparam int ROW_W  = SEGMENT_BYTES * 8;
  localparam int ROW_AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

  localparam int BUF_BYTES = WORD_BYTES - 1 + SEGMENT_BYTES;
  localparam int BUF_W     = BUF_BYTES * 8;
  localparam int BCNT_W    = $clog2(BUF_BYTES + 1);

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [ROW_AW-1:0] idx;
    logic [LEN_W-1:0]  len;
    logic [ROW_W-1:0]  data;
    logic [TOT_W-1:0]  total;
    logic [CS_W-1:0]   cs;
  } seg_t;

  function automatic logic [ROW_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int b = 0; b < SEGMENT_BYTES; b++) begin
      m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsr_seg_if.sv =====
// Segment input channel: valid/ready handshake with one label segment per word.
`timescale 1ns / 1ps
`default_nettype none
interface lsr_seg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  segment_index;
  logic [4:0]  segment_length;
  logic [63:0] segment_bytes_low;
  logic [63:0] segment_bytes_high;
  logic [3:0]  segment_total;
  logic [3:0]  label_charset;

  modport source (
    output valid, segment_index, segment_length, segment_bytes_low,
           segment_bytes_high, segment_total, label_charset,
    input  ready
  );
  modport sink (
    input  valid, segment_index, segment_length, segment_bytes_low,
           segment_bytes_high, segment_total, label_charset,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/lsr_msg_if.sv =====
// Message output channel: valid/ready handshake with up to eight label bytes per word.
`timescale 1ns / 1ps
`default_nettype none
interface lsr_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_bytes;
  logic [3:0]  byte_count;
  logic        last_of_message;
  logic [7:0]  message_length;
  logic [3:0]  message_charset;

  modport source (
    output valid, message_bytes, byte_count, last_of_message, message_length,
           message_charset,
    input  ready
  );
  modport sink (
    input  valid, message_bytes, byte_count, last_of_message, message_length,
           message_charset,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/label_segment_reassembler.sv =====
// Dynamic label segment reassembler top level.
//
// Takes one label segment per input word (index, 1 to 16 bytes, total segment
// count, charset) and keeps up to eight segments in a row-per-segment RAM.
// Words with a length of 0 or above 16 are dropped at the input. A two-entry
// queue sits between the input side and the processing side, so up to two
// segments are taken while a message is being sent. A segment that completes
// nothing goes through the processing side in order: read, compare and write,
// then decide. When a change is pending and segments 0 to total-1 are all
// present, the label goes out as 8-byte words, the last one flagged and
// possibly short. Sending fetches at most one stored row per cycle from the
// single RAM read port and sends at most one word per cycle.
`timescale 1ns / 1ps
`default_nettype none
module label_segment_reassembler (
  input  logic      clk,
  input  logic      rst_n,
  lsr_seg_if.sink   in_seg,
  lsr_msg_if.source out_msg
);
  import lsr_pkg::*;

  logic q_valid;
  logic q_pop;
  seg_t q_head;

  lsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  lsr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_msg (out_msg)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/lsr_front.sv =====
// Front end: accepts segment words, drops malformed ones, queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module lsr_front (
  input  logic          clk,
  input  logic          rst_n,
  lsr_seg_if.sink       in_seg,
  input  logic          q_pop,
  output logic          q_valid,
  output lsr_pkg::seg_t q_head
);
  import lsr_pkg::*;

  seg_t              q_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [IN_W-1:0]   raw;
  logic              keep;
  logic              push;
  seg_t              entry;

  assign raw  = {in_seg.segment_bytes_high, in_seg.segment_bytes_low};
  assign keep = (32'(in_seg.segment_index) < NUM_SEGMENTS) &&
                (in_seg.segment_length != '0) &&
                (32'(in_seg.segment_length) <= SEGMENT_BYTES);

  assign in_seg.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push         = in_seg.valid && in_seg.ready && keep;

  assign entry.idx   = in_seg.segment_index[ROW_AW-1:0];
  assign entry.len   = in_seg.segment_length;
  assign entry.data  = raw[ROW_W-1:0];
  assign entry.total = in_seg.segment_total;
  assign entry.cs    = in_seg.label_charset;

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);

  assign q_valid = (cnt_r != '0);
  assign q_head  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsr_back.sv =====
// Back end: compares and stores segments, then streams a completed label out in 8-byte words.
`timescale 1ns / 1ps
`default_nettype none
module lsr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lsr_pkg::seg_t q_head,
  output logic          q_pop,
  lsr_msg_if.source     out_msg
);
  import lsr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  seg_t              seg_r, seg_nxt;
  logic [LEN_W-1:0]  lens_r [NUM_SEGMENTS];
  logic [LEN_W-1:0]  lens_nxt [NUM_SEGMENTS];
  logic              pend_r, pend_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [CS_W-1:0]   cs_r, cs_nxt;
  logic [MLEN_W-1:0] mlen_r, mlen_nxt;
  logic [TOT_W-1:0]  rd_row_r, rd_row_nxt;
  logic              row_valid_r, row_valid_nxt;
  logic [LEN_W-1:0]  row_len_r, row_len_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;
  logic [MLEN_W-1:0] out_mlen_r, out_mlen_nxt;
  logic [CS_W-1:0]   out_cs_r, out_cs_nxt;

  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  logic              content_diff, changed;
  logic              complete;
  logic [MLEN_W-1:0] len_sum;
  logic              all_loaded, slot_free, full_word, emit, load, issue, last_word;
  logic [BCNT_W-1:0] cnt_a;
  logic [BUF_W-1:0]  buf_s;

  lsr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    complete = (tot_r != '0) && (32'(tot_r) <= NUM_SEGMENTS);
    len_sum  = '0;
    for (int i = 0; i < NUM_SEGMENTS; i++) begin
      if (i < int'(tot_r)) begin
        if (lens_r[i] == '0) begin
          complete = 1'b0;
        end
        len_sum = len_sum + MLEN_W'(lens_r[i]);
      end
    end
  end

  assign content_diff = |((ram_rdata ^ seg_r.data) & byte_mask(seg_r.len));
  assign changed      = content_diff || (lens_r[seg_r.idx] != seg_r.len) ||
                        (seg_r.total != tot_r) || (seg_r.cs != cs_r);

  assign all_loaded = (rd_row_r == tot_r) && !row_valid_r;
  assign slot_free  = !out_valid_r || out_msg.ready;
  assign full_word  = (bcnt_r >= BCNT_W'(WORD_BYTES));
  assign emit       = (state_r == ST_EMIT) && slot_free &&
                      (full_word || (all_loaded && (bcnt_r != '0)));
  assign cnt_a      = !emit ? bcnt_r :
                      (full_word ? bcnt_r - BCNT_W'(WORD_BYTES) : '0);
  assign buf_s      = emit ? (buf_r >> WORD_W) : buf_r;
  assign load       = (state_r == ST_EMIT) && row_valid_r &&
                      (cnt_a < BCNT_W'(WORD_BYTES));
  assign issue      = (state_r == ST_EMIT) && (rd_row_r < tot_r) &&
                      (!row_valid_r || load);
  assign last_word  = all_loaded && (bcnt_r <= BCNT_W'(WORD_BYTES));

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    lens_nxt      = lens_r;
    pend_nxt      = pend_r;
    tot_nxt       = tot_r;
    cs_nxt        = cs_r;
    mlen_nxt      = mlen_r;
    rd_row_nxt    = rd_row_r;
    row_valid_nxt = row_valid_r;
    row_len_nxt   = row_len_r;
    buf_nxt       = buf_r;
    bcnt_nxt      = bcnt_r;
    out_valid_nxt = out_valid_r && !out_msg.ready;
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    out_mlen_nxt  = out_mlen_r;
    out_cs_nxt    = out_cs_r;
    ram_we        = 1'b0;
    ram_waddr     = seg_r.idx;
    ram_wdata     = seg_r.data;
    ram_re        = 1'b0;
    ram_raddr     = rd_row_r[ROW_AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          seg_nxt   = q_head;
          ram_re    = 1'b1;
          ram_raddr = q_head.idx;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ram_we              = 1'b1;
        lens_nxt[seg_r.idx] = seg_r.len;
        tot_nxt             = seg_r.total;
        cs_nxt              = seg_r.cs;
        pend_nxt            = pend_r || changed;
        state_nxt           = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (pend_r && complete) begin
          mlen_nxt      = len_sum;
          rd_row_nxt    = '0;
          row_valid_nxt = 1'b0;
          buf_nxt       = '0;
          bcnt_nxt      = '0;
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        buf_nxt  = buf_s;
        bcnt_nxt = cnt_a;
        if (load) begin
          buf_nxt = buf_s |
                    (BUF_W'(ram_rdata & byte_mask(row_len_r)) << {cnt_a, 3'b000});
          bcnt_nxt      = cnt_a + BCNT_W'(row_len_r);
          row_valid_nxt = 1'b0;
        end
        if (issue) begin
          ram_re        = 1'b1;
          rd_row_nxt    = rd_row_r + 1'b1;
          row_valid_nxt = 1'b1;
          row_len_nxt   = lens_r[rd_row_r[ROW_AW-1:0]];
        end
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = buf_r[WORD_W-1:0];
          out_count_nxt = full_word ? CNT_W'(WORD_BYTES) : bcnt_r[CNT_W-1:0];
          out_last_nxt  = last_word;
          out_mlen_nxt  = mlen_r;
          out_cs_nxt    = cs_r;
          if (last_word) begin
            pend_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b1;
      tot_r       <= '0;
      cs_r        <= '0;
      row_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        lens_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      tot_r       <= tot_nxt;
      cs_r        <= cs_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      lens_r      <= lens_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r       <= seg_nxt;
    mlen_r      <= mlen_nxt;
    rd_row_r    <= rd_row_nxt;
    row_len_r   <= row_len_nxt;
    buf_r       <= buf_nxt;
    bcnt_r      <= bcnt_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
    out_mlen_r  <= out_mlen_nxt;
    out_cs_r    <= out_cs_nxt;
  end

  assign out_msg.valid           = out_valid_r;
  assign out_msg.message_bytes   = out_bytes_r;
  assign out_msg.byte_count      = out_count_r;
  assign out_msg.last_of_message = out_last_r;
  assign out_msg.message_length  = out_mlen_r;
  assign out_msg.message_charset = out_cs_r;

endmodule
`default_nettype wire

// ===== rtl/core/lsr_checker.sv =====
// Port-level checks on the reassembler's output words, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_message_bytes,
  input logic [3:0]  out_byte_count,
  input logic        out_last,
  input logic [7:0]  out_message_length
);
  import lsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_message_bytes) &&
                                $stable(out_byte_count) && $stable(out_last))
    else $error("output word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != '0) && (out_byte_count <= CNT_W'(WORD_BYTES)))
    else $error("byte count out of range");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte_count == CNT_W'(WORD_BYTES))
    else $error("short word before end of message");

  a_len_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_message_length == $past(out_message_length))
    else $error("message length changed within a message");

endmodule

bind label_segment_reassembler lsr_checker u_lsr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_msg.valid),
  .out_ready          (out_msg.ready),
  .out_message_bytes  (out_msg.message_bytes),
  .out_byte_count     (out_msg.byte_count),
  .out_last           (out_msg.last_of_message),
  .out_message_length (out_msg.message_length)
);
`default_nettype wire
